>>> src/sbm_pkg.sv
// package: shared types and constants of the serial bank mapper
`default_nettype none

package sbm_pkg;

    // access kinds on the input channel
    typedef enum logic [1:0] {
        KIND_CPU_RD = 2'd0,
        KIND_CPU_WR = 2'd1,
        KIND_PPU_RD = 2'd2,
        KIND_PPU_WR = 2'd3
    } kind_t;

    // loader target, chosen by address bits 14:13
    typedef enum logic [1:0] {
        TGT_CONTROL  = 2'd0,
        TGT_CHR_LOW  = 2'd1,
        TGT_CHR_HIGH = 2'd2,
        TGT_PRG      = 2'd3
    } target_t;

    // program mode field of the control register
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] PRG_COUNT_RESET = 6'd8;
    localparam logic [CFG_DATA_W-1:0] CHR_COUNT_RESET = 6'd0;

    localparam logic [4:0] CTRL_RESET = 5'h0C;
    localparam logic [2:0] LOAD_LEN   = 3'd5;

    localparam int ADDR_W = 20;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] bus_addr;
        logic [7:0]  write_data;
    } access_t;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [4:0] prg_bank;
    } bank_state_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] prg_count;
        logic [CFG_DATA_W-1:0] chr_count;
    } cart_cfg_t;

endpackage

`default_nettype wire

>>> src/sbm_regs.sv
// serial loader, bank registers and cartridge configuration registers
`default_nettype none

module sbm_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire sbm_pkg::access_t               acc,
    input  wire logic                           cfg_we,
    input  wire logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output sbm_pkg::bank_state_t                bank,
    output sbm_pkg::cart_cfg_t                  cfg,
    output logic [4:0]                          control_next
);
    import sbm_pkg::*;

    bank_state_t bank_reg;
    bank_state_t bank_next;
    cart_cfg_t   cfg_reg;
    cart_cfg_t   cfg_next;
    logic [4:0]  shift_reg;
    logic [4:0]  shift_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;

    always_comb
    begin
        logic [4:0] shift_fill;
        logic [2:0] count_inc;
        bank_next  = bank_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        shift_fill = {acc.write_data[0], shift_reg[4:1]};
        count_inc  = count_reg + 3'd1;
        if (step && acc.kind == KIND_CPU_WR && acc.bus_addr[15])
        begin
            if (acc.write_data[7])
            begin
                // loader reset, program mode forced to fixed-last
                shift_next        = '0;
                count_next        = '0;
                bank_next.control = bank_reg.control | CTRL_RESET;
            end
            else if (count_inc >= LOAD_LEN)
            begin
                unique case (target_t'(acc.bus_addr[14:13]))
                    TGT_CONTROL:  bank_next.control  = shift_fill;
                    TGT_CHR_LOW:  bank_next.chr_low  = shift_fill;
                    TGT_CHR_HIGH: bank_next.chr_high = shift_fill;
                    TGT_PRG:      bank_next.prg_bank = shift_fill;
                    default:      bank_next.prg_bank = shift_fill;
                endcase
                shift_next = '0;
                count_next = '0;
            end
            else
            begin
                shift_next = shift_fill;
                count_next = count_inc;
            end
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRG_COUNT: cfg_next.prg_count = cfg_data;
                CFG_CHR_COUNT: cfg_next.chr_count = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg.control   <= CTRL_RESET;
            bank_reg.chr_low   <= '0;
            bank_reg.chr_high  <= '0;
            bank_reg.prg_bank  <= '0;
            cfg_reg.prg_count  <= PRG_COUNT_RESET;
            cfg_reg.chr_count  <= CHR_COUNT_RESET;
            shift_reg          <= '0;
            count_reg          <= '0;
        end
        else
        begin
            bank_reg  <= bank_next;
            cfg_reg   <= cfg_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

    assign bank         = bank_reg;
    assign cfg          = cfg_reg;
    assign control_next = bank_next.control;

endmodule

`default_nettype wire

>>> src/sbm_map.sv
// address translation of one bus access into a cartridge address
`default_nettype none

module sbm_map (
    input  wire sbm_pkg::access_t            acc,
    input  wire sbm_pkg::bank_state_t        bank,
    input  wire sbm_pkg::cart_cfg_t          cfg,
    output logic                             hit,
    output logic [sbm_pkg::ADDR_W-1:0]       cart_addr
);
    import sbm_pkg::*;

    always_comb
    begin
        logic [15:0]           a;
        logic [1:0]            mode;
        logic [3:0]            prg;
        logic [CFG_DATA_W-1:0] last;
        logic [ADDR_W-1:0]     ram_addr;
        logic [ADDR_W-1:0]     m;
        logic                  h;
        a        = acc.bus_addr;
        mode     = bank.control[3:2];
        prg      = bank.prg_bank[3:0];
        last     = cfg.prg_count - 6'd1;
        // program ram sits right past program rom
        ram_addr = {cfg.prg_count, 1'b0, a[12:0]};
        m        = '0;
        h        = 1'b0;
        unique case (acc.kind)
            KIND_CPU_RD:
            begin
                if (a[15])
                begin
                    h = 1'b1;
                    if (!mode[1])
                        m = {2'b00, prg[3:1], a[14:0]};
                    else if (!a[14])
                        m = (mode == PRG_MODE_FIX_FIRST) ? {6'd0, a[13:0]}
                                                         : {2'b00, prg, a[13:0]};
                    else
                        m = (mode == PRG_MODE_FIX_FIRST) ? {2'b00, prg, a[13:0]}
                                                         : {last, a[13:0]};
                end
                else if (a[14:13] == 2'b11)
                begin
                    h = 1'b1;
                    m = ram_addr;
                end
            end
            KIND_CPU_WR:
            begin
                // loader writes never hit
                if (!a[15] && a[14:13] == 2'b11)
                begin
                    h = 1'b1;
                    m = ram_addr;
                end
            end
            KIND_PPU_RD:
            begin
                if (a[15:13] == 3'b000)
                begin
                    h = 1'b1;
                    if (cfg.chr_count == '0)
                        m = {7'd0, a[12:0]};
                    else if (!bank.control[4])
                        m = {3'd0, bank.chr_low[4:1], a[12:0]};
                    else if (!a[12])
                        m = {3'd0, bank.chr_low, a[11:0]};
                    else
                        m = {3'd0, bank.chr_high, a[11:0]};
                end
            end
            KIND_PPU_WR:
            begin
                // only pattern ram takes writes
                if (a[15:13] == 3'b000 && cfg.chr_count == '0)
                begin
                    h = 1'b1;
                    m = {7'd0, a[12:0]};
                end
            end
            default:
            begin
                h = 1'b0;
            end
        endcase
        hit       = h;
        cart_addr = h ? m : '0;
    end

endmodule

`default_nettype wire

>>> src/serial_bank_mapper_top.sv
// top level of the serial bank mapper: input stage, translation, result stage
// an accepted item is registered in the input stage, then in the result stage
// throughput: one item per cycle while the result port is not stalled; translation is combinational
// while a finished result waits, the input stage takes one more item and then stalls
// reset: asynchronous, active low; empties both stages, clears the loader, resets the bank and config registers
// after reset control is 0x0C (fixed-last program mode), 8 program banks, pattern ram
`default_nettype none

module serial_bank_mapper_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input item channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     kind,
    input  wire logic [15:0]                    bus_addr,
    input  wire logic [7:0]                     write_data,
    // result item channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                hit,
    output logic [sbm_pkg::ADDR_W-1:0]          cart_addr,
    output logic [1:0]                          mirroring,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sbm_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    access_t     acc_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [1:0]        mirror_reg;

    // datapath between the stages
    bank_state_t       bank;
    cart_cfg_t         cfg;
    logic [4:0]        control_next;
    logic              map_hit;
    logic [ADDR_W-1:0] map_addr;

    logic in_take;
    logic out_load;
    logic step;

    // result stage can take a new item when empty or being drained
    assign out_load = !out_valid_reg || !out_stall;
    // the item in the input stage moves on, and updates mapper state, here
    assign step     = in_valid_reg && out_load;
    assign in_stall = in_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    // configuration is always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    sbm_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .acc          (acc_reg),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .bank         (bank),
        .cfg          (cfg),
        .control_next (control_next)
    );

    // translation uses the state before this item's own loader update
    sbm_map u_map (
        .acc       (acc_reg),
        .bank      (bank),
        .cfg       (cfg),
        .hit       (map_hit),
        .cart_addr (map_addr)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            acc_reg.kind       <= kind_t'(kind);
            acc_reg.bus_addr   <= bus_addr;
            acc_reg.write_data <= write_data;
        end
        if (step)
        begin
            hit_reg    <= map_hit;
            addr_reg   <= map_addr;
            // mirroring reflects the control register after this item
            mirror_reg <= control_next[1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cart_addr = addr_reg;
    assign mirroring = mirror_reg;

endmodule

`default_nettype wire

>>> src/sbm_checker.sv
// port-level checks of the serial bank mapper and their bind
`default_nettype none

module sbm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic                           hit,
    input wire logic [sbm_pkg::ADDR_W-1:0]     cart_addr,
    input wire logic [1:0]                     mirroring,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(cart_addr)
            && $stable(mirroring))
        else $error("stalled result changed");

    // a miss carries a zero address
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cart_addr == '0)
        else $error("miss with nonzero address");

    // input side backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // the configuration port never blocks
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind serial_bank_mapper_top sbm_checker u_sbm_checker (.*);

`default_nettype wire
